// ===== rtl/aet_pkg.sv =====
// shared types, constants and codes of the absolute encoder tracker
`default_nettype none
package aet_pkg;

   // field and datapath widths
   localparam int RAW_W   = 12;
   localparam int CPR_W   = 16;
   localparam int PP_W    = 8;
   localparam int US_W    = 20;
   localparam int ANG_W   = 16;
   localparam int TOT_W   = 48;
   localparam int SPD_W   = 24;
   localparam int FTOT_W  = 32;
   localparam int DELTA_W = 18;
   localparam int DIV_W   = 48;
   localparam int DVS_W   = 36;
   localparam int CNT_W   = 6;
   localparam int IDX_W   = 3;
   localparam int CSR_W   = 16;

   // rpm q4 scale: 60 s * 16 * 1e6 us
   localparam logic [29:0] RPM_SCALE = 30'd960000000;
   localparam logic [DIV_W-1:0] SPEED_POS_LIM = 48'd8388607;
   localparam logic [DIV_W-1:0] SPEED_NEG_LIM = 48'd8388608;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_CPR    = 3'd0;
   localparam logic [IDX_W-1:0] CSR_POLES  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_OFFSET = 3'd2;
   localparam logic [IDX_W-1:0] CSR_REV    = 3'd3;
   localparam logic [IDX_W-1:0] CSR_THRESH = 3'd4;

   // function codes
   localparam logic [1:0] FN_UPDATE = 2'd0;
   localparam logic [1:0] FN_START  = 2'd1;
   localparam logic [1:0] FN_STOP   = 2'd2;
   localparam logic [1:0] FN_ZERO   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_REJ  = 2'd2;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NONE,
      OP_DECODE,
      OP_UNWRAP,
      OP_ACCUM,
      OP_DIV_POS,
      OP_POS_FIX,
      OP_DIV_MECH,
      OP_MECH_FIX,
      OP_DIV_SPD,
      OP_SPEED,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      logic      load;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic go_update;
      logic div_done;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== rtl/aet_req_if.sv =====
// request channel: one encoder command with its reading
`default_nettype none
interface aet_req_if;
   import aet_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       func;
   logic [RAW_W-1:0] sensor_angle;
   logic             read_ok;
   logic [US_W-1:0]  elapsed_us;

   modport source (output valid, func, sensor_angle, read_ok, elapsed_us, input ready);
   modport sink   (input valid, func, sensor_angle, read_ok, elapsed_us, output ready);
endinterface
`default_nettype wire

// ===== rtl/aet_rsp_if.sv =====
// response channel: tracker result of one command
`default_nettype none
interface aet_rsp_if;
   import aet_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic                     valid_res;
   logic [ANG_W-1:0]         mech_angle;
   logic [ANG_W-1:0]         elec_angle;
   logic signed [15:0]       delta_counts;
   logic signed [SPD_W-1:0]  speed_rpm_q4;
   logic signed [TOT_W-1:0]  turn_count_total;
   logic [15:0]              fail_run;
   logic [FTOT_W-1:0]        fail_total;
   logic                     recover_request;

   modport source (output valid, status, valid_res, mech_angle, elec_angle, delta_counts,
                   speed_rpm_q4, turn_count_total, fail_run, fail_total, recover_request,
                   input ready);
   modport sink   (input valid, status, valid_res, mech_angle, elec_angle, delta_counts,
                   speed_rpm_q4, turn_count_total, fail_run, fail_total, recover_request,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/aet_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module aet_div
   import aet_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DIV_W-1:0]      quotient,
   output logic [DVS_W-1:0]      remainder
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   trial, diff;
   logic             take;

   // one shift-subtract step
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      take   = trial >= {1'b0, dvs_ff};
      rem_in = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_in = {quo_ff[DIV_W-2:0], take};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands and partial results
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ===== rtl/aet_dp.sv =====
// tracker datapath: registers, state, arithmetic and the result register
`default_nettype none
module aet_dp
   import aet_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dp_cmd_type       cmd,
   output dp_stat_type           stat,
   input  wire logic [1:0]       in_func,
   input  wire logic [RAW_W-1:0] in_raw,
   input  wire logic             in_ok,
   input  wire logic [US_W-1:0]  in_us,
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   output logic [1:0]            out_status,
   output logic                  out_valid_res,
   output logic [ANG_W-1:0]      out_mech,
   output logic [ANG_W-1:0]      out_elec,
   output logic [15:0]           out_delta,
   output logic [SPD_W-1:0]      out_speed,
   output logic [TOT_W-1:0]      out_total,
   output logic [15:0]           out_frun,
   output logic [FTOT_W-1:0]     out_ftot,
   output logic                  out_recover
);

   // configuration
   logic [CPR_W-1:0] cpr_ff;
   logic [PP_W-1:0]  pp_ff;
   logic [ANG_W-1:0] off_ff;
   logic             rev_ff;
   logic [15:0]      thr_ff;

   // captured item
   logic [1:0]       func_ff;
   logic [RAW_W-1:0] raw_ff;
   logic             ok_ff;
   logic [US_W-1:0]  us_ff;

   // tracker state
   logic [CPR_W-1:0]  prev_ff, pos_ff;
   logic [TOT_W-1:0]  total_ff;
   logic              run_ff, valid_ff;
   logic [15:0]       frun_ff;
   logic [FTOT_W-1:0] ftot_ff;
   logic [ANG_W-1:0]  mech_ff, elec_ff;
   logic [SPD_W-1:0]  speed_ff;

   // per item work registers
   logic [1:0]               status_ff;
   logic                     recover_ff;
   logic signed [DELTA_W-1:0] delta_ff;
   logic [CPR_W-1:0]         now_ff;
   logic [DVS_W-1:0]         den_ff;
   logic [DIV_W-1:0]         num_ff;
   logic                     sneg_ff, tneg_ff;

   // divider hookup
   logic             div_start, div_done;
   logic [DIV_W-1:0] div_dividend, div_quo;
   logic [DVS_W-1:0] div_divisor, div_rem;

   aet_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // combinational helpers
   logic [RAW_W+CPR_W-1:0]    count_prod;
   logic [CPR_W-1:0]          count_w;
   logic [15:0]               frun_next;
   logic                      reject;
   logic signed [DELTA_W-1:0] diff_w, half_w, cpr_s, unwrap_w, delta_w;
   logic [DELTA_W-2:0]        absd_w;
   logic [TOT_W-1:0]          tot_mag;
   logic [CPR_W-1:0]          rem16, pos_w;
   logic [23:0]               elec_prod;
   logic [SPD_W-1:0]          speed_w;

   always_comb begin
      count_prod = {{CPR_W{1'b0}}, raw_ff} * {{RAW_W{1'b0}}, cpr_ff};
      count_w    = count_prod[RAW_W+CPR_W-1:RAW_W];
      frun_next  = (frun_ff == 16'hFFFF) ? frun_ff : frun_ff + 16'd1;
      reject     = (cpr_ff == '0) || !run_ff || (us_ff == '0);

      // half-turn unwrap of the count difference
      diff_w = $signed({2'b00, now_ff}) - $signed({2'b00, prev_ff});
      half_w = $signed({3'b000, cpr_ff[CPR_W-1:1]});
      cpr_s  = $signed({2'b00, cpr_ff});
      if (diff_w > half_w)
         unwrap_w = diff_w - cpr_s;
      else if (diff_w < -half_w)
         unwrap_w = diff_w + cpr_s;
      else
         unwrap_w = diff_w;
      delta_w = rev_ff ? -unwrap_w : unwrap_w;

      absd_w  = delta_ff[DELTA_W-1] ? 17'(-delta_ff) : 17'(delta_ff);
      tot_mag = total_ff[TOT_W-1] ? -total_ff : total_ff;

      // remainder of a negative total folds back into one turn
      rem16 = div_rem[CPR_W-1:0];
      pos_w = (tneg_ff && rem16 != '0) ? cpr_ff - rem16 : rem16;

      elec_prod = {8'b0, div_quo[ANG_W-1:0]} * {16'b0, pp_ff};

      // speed saturation
      if (!sneg_ff)
         speed_w = (div_quo > SPEED_POS_LIM) ? 24'h7FFFFF : div_quo[SPD_W-1:0];
      else
         speed_w = (div_quo > SPEED_NEG_LIM) ? 24'h800000 : -div_quo[SPD_W-1:0];
   end

   // divider operand select
   always_comb begin
      div_start    = 1'b0;
      div_dividend = num_ff;
      div_divisor  = den_ff;
      case (cmd.op)
         OP_DIV_POS: begin
            div_start    = 1'b1;
            div_dividend = tot_mag;
            div_divisor  = {{(DVS_W-CPR_W){1'b0}}, cpr_ff};
         end
         OP_DIV_MECH: begin
            div_start    = 1'b1;
            div_dividend = {{(DIV_W-CPR_W-ANG_W){1'b0}}, pos_ff, {ANG_W{1'b0}}};
            div_divisor  = {{(DVS_W-CPR_W){1'b0}}, cpr_ff};
         end
         OP_DIV_SPD: begin
            div_start = 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   assign stat.go_update = (func_ff == FN_UPDATE) && !reject && ok_ff;
   assign stat.div_done  = div_done;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff <= 16'd4096;
         pp_ff  <= 8'd1;
         off_ff <= '0;
         rev_ff <= 1'b0;
         thr_ff <= 16'd3;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CPR:    cpr_ff <= csr_wdata;
            CSR_POLES:  pp_ff  <= csr_wdata[PP_W-1:0];
            CSR_OFFSET: off_ff <= csr_wdata;
            CSR_REV:    rev_ff <= csr_wdata[0];
            CSR_THRESH: thr_ff <= csr_wdata;
            default:    cpr_ff <= cpr_ff;
         endcase
      end
   end

   // item capture and work registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= in_func;
         raw_ff  <= in_raw;
         ok_ff   <= in_ok;
         us_ff   <= in_us;
      end
      case (cmd.op)
         OP_DECODE: begin
            now_ff <= count_w;
            den_ff <= {{(DVS_W-CPR_W){1'b0}}, cpr_ff} * {{(DVS_W-US_W){1'b0}}, us_ff};
         end
         OP_ACCUM: begin
            num_ff  <= {{(DIV_W-DELTA_W+1){1'b0}}, absd_w} * {18'b0, RPM_SCALE};
            sneg_ff <= delta_ff[DELTA_W-1];
         end
         OP_DIV_POS: tneg_ff <= total_ff[TOT_W-1];
         default:    now_ff  <= now_ff;
      endcase
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         pos_ff     <= '0;
         total_ff   <= '0;
         run_ff     <= 1'b0;
         valid_ff   <= 1'b0;
         frun_ff    <= '0;
         ftot_ff    <= '0;
         mech_ff    <= '0;
         elec_ff    <= '0;
         speed_ff   <= '0;
         status_ff  <= ST_OK;
         recover_ff <= 1'b0;
         delta_ff   <= '0;
      end else begin
         case (cmd.op)
            OP_DECODE: begin
               status_ff  <= ST_OK;
               recover_ff <= 1'b0;
               delta_ff   <= '0;
               case (func_ff)
                  FN_UPDATE, FN_START: begin
                     if ((func_ff == FN_UPDATE) ? reject : (cpr_ff == '0)) begin
                        status_ff <= ST_REJ;
                     end else if (!ok_ff) begin
                        status_ff  <= ST_FAIL;
                        ftot_ff    <= ftot_ff + 32'd1;
                        frun_ff    <= frun_next;
                        valid_ff   <= 1'b0;
                        speed_ff   <= '0;
                        recover_ff <= frun_next >= thr_ff;
                     end else begin
                        frun_ff  <= '0;
                        valid_ff <= 1'b1;
                        if (func_ff == FN_START) begin
                           prev_ff  <= count_w;
                           total_ff <= '0;
                           speed_ff <= '0;
                           run_ff   <= 1'b1;
                        end
                     end
                  end
                  FN_STOP: begin
                     run_ff   <= 1'b0;
                     speed_ff <= '0;
                  end
                  default: begin
                     if (ok_ff) begin
                        prev_ff  <= count_w;
                        frun_ff  <= '0;
                        valid_ff <= 1'b1;
                     end else begin
                        status_ff <= ST_FAIL;
                     end
                     total_ff <= '0;
                     pos_ff   <= '0;
                     mech_ff  <= '0;
                     elec_ff  <= -off_ff;
                     speed_ff <= '0;
                  end
               endcase
            end
            OP_UNWRAP: begin
               delta_ff <= delta_w;
               prev_ff  <= now_ff;
            end
            OP_ACCUM:   total_ff <= total_ff + {{(TOT_W-DELTA_W){delta_ff[DELTA_W-1]}}, delta_ff};
            OP_POS_FIX: pos_ff   <= pos_w;
            OP_MECH_FIX: begin
               mech_ff <= div_quo[ANG_W-1:0];
               elec_ff <= elec_prod[ANG_W-1:0] - off_ff;
            end
            OP_SPEED: speed_ff <= speed_w;
            default:  speed_ff <= speed_ff;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUBLISH) begin
         out_status    <= status_ff;
         out_valid_res <= valid_ff;
         out_mech      <= mech_ff;
         out_elec      <= elec_ff;
         out_delta     <= delta_ff[15:0];
         out_speed     <= speed_ff;
         out_total     <= total_ff;
         out_frun      <= frun_ff;
         out_ftot      <= ftot_ff;
         out_recover   <= recover_ff;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/aet_ctrl.sv =====
// tracker sequencer: steps the datapath through one command
`default_nettype none
module aet_ctrl
   import aet_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_UNWRAP,
      S_ACCUM,
      S_POS_START,
      S_POS_WAIT,
      S_POS_FIX,
      S_MECH_START,
      S_MECH_WAIT,
      S_MECH_FIX,
      S_SPD_START,
      S_SPD_WAIT,
      S_SPEED,
      S_PUBLISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      pub_ok;

   assign pub_ok    = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd.load = req_ready && req_valid;
      case (state_ff)
         S_DECODE:     cmd.op = OP_DECODE;
         S_UNWRAP:     cmd.op = OP_UNWRAP;
         S_ACCUM:      cmd.op = OP_ACCUM;
         S_POS_START:  cmd.op = OP_DIV_POS;
         S_POS_FIX:    cmd.op = OP_POS_FIX;
         S_MECH_START: cmd.op = OP_DIV_MECH;
         S_MECH_FIX:   cmd.op = OP_MECH_FIX;
         S_SPD_START:  cmd.op = OP_DIV_SPD;
         S_SPEED:      cmd.op = OP_SPEED;
         S_PUBLISH:    cmd.op = pub_ok ? OP_PUBLISH : OP_NONE;
         default:      cmd.op = OP_NONE;
      endcase
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_PUBLISH && pub_ok)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE:       if (req_valid) state_ff <= S_DECODE;
            S_DECODE:     state_ff <= stat.go_update ? S_UNWRAP : S_PUBLISH;
            S_UNWRAP:     state_ff <= S_ACCUM;
            S_ACCUM:      state_ff <= S_POS_START;
            S_POS_START:  state_ff <= S_POS_WAIT;
            S_POS_WAIT:   if (stat.div_done) state_ff <= S_POS_FIX;
            S_POS_FIX:    state_ff <= S_MECH_START;
            S_MECH_START: state_ff <= S_MECH_WAIT;
            S_MECH_WAIT:  if (stat.div_done) state_ff <= S_MECH_FIX;
            S_MECH_FIX:   state_ff <= S_SPD_START;
            S_SPD_START:  state_ff <= S_SPD_WAIT;
            S_SPD_WAIT:   if (stat.div_done) state_ff <= S_SPEED;
            S_SPEED:      state_ff <= S_PUBLISH;
            S_PUBLISH:    if (pub_ok) state_ff <= S_IDLE;
            default:      state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/absolute_encoder_tracker_core.sv =====
// top level of the absolute encoder multi-turn position and speed tracker
//
// req_chan carries one command per transfer: update, start, stop or set zero,
// with the raw 12-bit angle, the read result and the elapsed time. rsp_chan
// returns exactly one result per command. The csr_ port writes the five
// configuration registers at any edge with csr_we high; the user must keep
// such writes to times when the block is idle; the block does not enforce it.
// One command is worked at a time. Start, stop, set zero and rejected or
// failed updates go from decode straight to the publish step. An accepted
// update steps through unwrap and accumulate, then the shared 48-step
// restoring divider runs three times (position modulo counts per turn,
// mechanical angle, speed), each run with a start and a fix-up step.
// The result sits in an output register; the next command is taken while it
// waits, and a stalled receiver only holds the block at its final step.
// Reset is synchronous: it loads the register defaults, clears all tracking
// state and leaves no result pending.
`default_nettype none
module absolute_encoder_tracker_core
   import aet_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   aet_req_if.sink               req_chan,
   aet_rsp_if.source             rsp_chan,
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready, rsp_valid;
   logic [15:0]      out_delta;
   logic [SPD_W-1:0] out_speed;
   logic [TOT_W-1:0] out_total;

   aet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   aet_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .in_func       (req_chan.func),
      .in_raw        (req_chan.sensor_angle),
      .in_ok         (req_chan.read_ok),
      .in_us         (req_chan.elapsed_us),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .out_status    (rsp_chan.status),
      .out_valid_res (rsp_chan.valid_res),
      .out_mech      (rsp_chan.mech_angle),
      .out_elec      (rsp_chan.elec_angle),
      .out_delta     (out_delta),
      .out_speed     (out_speed),
      .out_total     (out_total),
      .out_frun      (rsp_chan.fail_run),
      .out_ftot      (rsp_chan.fail_total),
      .out_recover   (rsp_chan.recover_request)
   );

   assign req_chan.ready            = req_ready;
   assign rsp_chan.valid            = rsp_valid;
   assign rsp_chan.delta_counts     = $signed(out_delta);
   assign rsp_chan.speed_rpm_q4     = $signed(out_speed);
   assign rsp_chan.turn_count_total = $signed(out_total);

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench of the absolute encoder tracker core
`default_nettype none
module testbench;
   import aet_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic        valid_res;
      logic [15:0] mech_angle;
      logic [15:0] elec_angle;
      logic [15:0] delta_counts;
      logic [23:0] speed_rpm_q4;
      logic [47:0] turn_count_total;
      logic [15:0] fail_run;
      logic [31:0] fail_total;
      logic        recover_request;
   } tracker_result_t;

   typedef struct {
      logic [1:0]  func;
      logic [11:0] raw;
      logic        ok;
      logic [19:0] us;
      logic        typed;   // status typed in below
      logic [1:0]  status;
   } cmd_row_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   aet_req_if req_chan ();
   aet_rsp_if rsp_chan ();

   absolute_encoder_tracker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted configuration and tracking state
   logic [15:0] cfg_cpr;
   logic [7:0]  cfg_poles;
   logic [15:0] cfg_offset;
   logic        cfg_reverse;
   logic [15:0] cfg_thresh;
   logic [15:0] prev_count;
   logic [15:0] turn_pos;
   logic [47:0] multi_turn;
   logic        is_running;
   logic        last_good;
   logic [15:0] fail_streak;
   logic [31:0] fail_sum;
   logic [15:0] mech_now;
   logic [15:0] elec_now;
   logic [23:0] speed_now;

   tracker_result_t expected_results[$];
   int mismatches;
   int updates_done;
   int failures_seen;
   int configs_done;
   bit gaps_on;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit on the run
   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

   // multi-turn tracker prediction for one command
   task automatic predict_tracker(input logic [1:0] func, input logic [11:0] raw,
                                  input logic ok, input logic [19:0] us,
                                  output tracker_result_t r);
      longint cpr, now_cnt, half, d, ts, p, num, den, mag, spd, mq;
      logic [1:0] st;
      logic rec;
      logic [15:0] dl;
      cpr = longint'(cfg_cpr);
      now_cnt = (longint'(raw) * cpr) / 4096;
      st = ST_OK;
      rec = 1'b0;
      dl = '0;
      case (func)
         FN_UPDATE: begin
            if (cfg_cpr == 0 || !is_running || us == 0) begin
               st = ST_REJ;
            end else if (!ok) begin
               st = ST_FAIL;
            end else begin
               fail_streak = '0;
               last_good = 1'b1;
               half = cpr / 2;
               d = now_cnt - longint'(prev_count);
               if (d > half) d = d - cpr;
               else if (d < -half) d = d + cpr;
               if (cfg_reverse) d = -d;
               prev_count = now_cnt[15:0];
               multi_turn = multi_turn + d[47:0];
               ts = {{16{multi_turn[47]}}, multi_turn};
               p = ts % cpr;
               if (p < 0) p = p + cpr;
               turn_pos = p[15:0];
               mq = (p << 16) / cpr;
               mech_now = mq[15:0];
               elec_now = mech_now * cfg_poles - cfg_offset;
               num = d * 64'sd960000000;
               den = cpr * longint'(us);
               mag = (num < 0 ? -num : num) / den;
               spd = num < 0 ? -mag : mag;
               if (spd > 8388607) spd = 8388607;
               if (spd < -8388608) spd = -8388608;
               speed_now = spd[23:0];
               dl = d[15:0];
               updates_done++;
            end
         end
         FN_START: begin
            if (cfg_cpr == 0) begin
               st = ST_REJ;
            end else if (!ok) begin
               st = ST_FAIL;
            end else begin
               prev_count = now_cnt[15:0];
               fail_streak = '0;
               last_good = 1'b1;
               multi_turn = '0;
               speed_now = '0;
               is_running = 1'b1;
            end
         end
         FN_STOP: begin
            is_running = 1'b0;
            speed_now = '0;
         end
         default: begin
            if (ok) begin
               prev_count = now_cnt[15:0];
               fail_streak = '0;
               last_good = 1'b1;
            end else begin
               st = ST_FAIL;
            end
            multi_turn = '0;
            turn_pos = '0;
            mech_now = '0;
            elec_now = 16'd0 - cfg_offset;
            speed_now = '0;
         end
      endcase
      // read failure bookkeeping on update and start
      if (st == ST_FAIL && func != FN_ZERO) begin
         fail_sum = fail_sum + 32'd1;
         if (fail_streak != 16'hFFFF) fail_streak = fail_streak + 16'd1;
         last_good = 1'b0;
         speed_now = '0;
         rec = fail_streak >= cfg_thresh;
         failures_seen++;
      end
      r.status = st;
      r.valid_res = last_good;
      r.mech_angle = mech_now;
      r.elec_angle = elec_now;
      r.delta_counts = dl;
      r.speed_rpm_q4 = speed_now;
      r.turn_count_total = multi_turn;
      r.fail_run = fail_streak;
      r.fail_total = fail_sum;
      r.recover_request = rec;
   endtask

   // drive one command until its transfer, recording the expectation
   task automatic send_cmd(input cmd_row_t c);
      tracker_result_t r;
      predict_tracker(c.func, c.raw, c.ok, c.us, r);
      if (c.typed) r.status = c.status;
      if (gaps_on && $urandom_range(99) < 36) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 36);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= c.func;
      req_chan.sensor_angle <= c.raw;
      req_chan.read_ok <= c.ok;
      req_chan.elapsed_us <= c.us;
      expected_results.push_back(r);
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // let every outstanding result drain, then a few quiet cycles
   task automatic wait_idle();
      int guard;
      req_chan.valid <= 1'b0;
      guard = 0;
      while (expected_results.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_CPR:    cfg_cpr = val;
         CSR_POLES:  cfg_poles = val[7:0];
         CSR_OFFSET: cfg_offset = val;
         CSR_REV:    cfg_reverse = val[0];
         default:    cfg_thresh = val;
      endcase
      configs_done++;
   endtask

   function automatic logic [19:0] pick_us();
      case ($urandom_range(9))
         0: pick_us = 20'd0;
         1: pick_us = 20'hFFFFF;
         2: pick_us = 20'd1;
         3, 4: pick_us = 20'($urandom_range(20'hFFFFF));
         default: pick_us = 20'($urandom_range(2000, 1));
      endcase
   endfunction

   function automatic logic [15:0] pick_edge(input logic [15:0] lo, input logic [15:0] hi);
      case ($urandom_range(3))
         0: pick_edge = lo;
         1: pick_edge = hi;
         default: pick_edge = 16'($urandom_range(hi, lo));
      endcase
   endfunction

   // result checking on each transfer
   always @(posedge clock) begin
      tracker_result_t e;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= gaps_on ? ($urandom_range(99) >= 36) : 1'b1;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with no expectation waiting");
               mismatches++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_chan.status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_chan.status);
                  mismatches++;
               end
               if (rsp_chan.valid_res !== e.valid_res) begin
                  $error("valid_res exp %0d got %0d", e.valid_res, rsp_chan.valid_res);
                  mismatches++;
               end
               if (rsp_chan.mech_angle !== e.mech_angle) begin
                  $error("mech_angle exp %0d got %0d", e.mech_angle, rsp_chan.mech_angle);
                  mismatches++;
               end
               if (rsp_chan.elec_angle !== e.elec_angle) begin
                  $error("elec_angle exp %0d got %0d", e.elec_angle, rsp_chan.elec_angle);
                  mismatches++;
               end
               if (rsp_chan.delta_counts !== e.delta_counts) begin
                  $error("delta_counts exp %h got %h", e.delta_counts, rsp_chan.delta_counts);
                  mismatches++;
               end
               if (rsp_chan.speed_rpm_q4 !== e.speed_rpm_q4) begin
                  $error("speed_rpm_q4 exp %h got %h", e.speed_rpm_q4, rsp_chan.speed_rpm_q4);
                  mismatches++;
               end
               if (rsp_chan.turn_count_total !== e.turn_count_total) begin
                  $error("turn_count_total exp %h got %h", e.turn_count_total,
                         rsp_chan.turn_count_total);
                  mismatches++;
               end
               if (rsp_chan.fail_run !== e.fail_run) begin
                  $error("fail_run exp %0d got %0d", e.fail_run, rsp_chan.fail_run);
                  mismatches++;
               end
               if (rsp_chan.fail_total !== e.fail_total) begin
                  $error("fail_total exp %0d got %0d", e.fail_total, rsp_chan.fail_total);
                  mismatches++;
               end
               if (rsp_chan.recover_request !== e.recover_request) begin
                  $error("recover_request exp %0d got %0d", e.recover_request,
                         rsp_chan.recover_request);
                  mismatches++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      cmd_row_t dir_table[18];
      cmd_row_t c;
      int n;
      int phase;
      int guard;
      logic [11:0] walk;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.func = FN_UPDATE;
      req_chan.sensor_angle = '0;
      req_chan.read_ok = 1'b0;
      req_chan.elapsed_us = '0;
      gaps_on = 1'b1;
      mismatches = 0;
      updates_done = 0;
      failures_seen = 0;
      configs_done = 0;
      cfg_cpr = 16'd4096;
      cfg_poles = 8'd1;
      cfg_offset = '0;
      cfg_reverse = 1'b0;
      cfg_thresh = 16'd3;
      prev_count = '0;
      turn_pos = '0;
      multi_turn = '0;
      is_running = 1'b0;
      last_good = 1'b0;
      fail_streak = '0;
      fail_sum = '0;
      mech_now = '0;
      elec_now = '0;
      speed_now = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rejections, failures, unwrap at half a turn, saturation
      dir_table = '{
         '{FN_UPDATE, 12'd0,    1'b1, 20'd100,     1'b1, ST_REJ},
         '{FN_STOP,   12'd0,    1'b1, 20'd0,       1'b1, ST_OK},
         '{FN_START,  12'd7,    1'b0, 20'd0,       1'b1, ST_FAIL},
         '{FN_START,  12'd0,    1'b1, 20'd0,       1'b1, ST_OK},
         '{FN_UPDATE, 12'd5,    1'b1, 20'd0,       1'b1, ST_REJ},
         '{FN_UPDATE, 12'hFFF,  1'b1, 20'd1,       1'b1, ST_OK},
         '{FN_UPDATE, 12'd2048, 1'b1, 20'hFFFFF,   1'b1, ST_OK},
         '{FN_UPDATE, 12'd0,    1'b1, 20'd1,       1'b1, ST_OK},
         '{FN_UPDATE, 12'd2048, 1'b1, 20'd1,       1'b1, ST_OK},
         '{FN_UPDATE, 12'd10,   1'b0, 20'd50,      1'b1, ST_FAIL},
         '{FN_UPDATE, 12'd10,   1'b0, 20'd50,      1'b1, ST_FAIL},
         '{FN_UPDATE, 12'd10,   1'b0, 20'd50,      1'b1, ST_FAIL},
         '{FN_ZERO,   12'd33,   1'b0, 20'd0,       1'b1, ST_FAIL},
         '{FN_ZERO,   12'd100,  1'b1, 20'd0,       1'b1, ST_OK},
         '{FN_UPDATE, 12'hAAA,  1'b1, 20'd555,     1'b1, ST_OK},
         '{FN_STOP,   12'd0,    1'b0, 20'd9,       1'b1, ST_OK},
         '{FN_UPDATE, 12'h555,  1'b1, 20'd10,      1'b1, ST_REJ},
         '{FN_START,  12'd1234, 1'b1, 20'd0,       1'b1, ST_OK}
      };
      foreach (dir_table[i]) send_cmd(dir_table[i]);
      wait_idle();

      // random phases, each with its own register setting
      n = 0;
      phase = 0;
      while (n < 500) begin
         if (phase == 0) begin
            write_reg(CSR_CPR, 16'd2);
            write_reg(CSR_POLES, 16'd255);
            write_reg(CSR_OFFSET, 16'hFFFF);
            write_reg(CSR_REV, 16'd1);
            write_reg(CSR_THRESH, 16'd1);
         end else if (phase == 1) begin
            write_reg(CSR_CPR, 16'hFFFF);
            write_reg(CSR_THRESH, 16'hFFFF);
            write_reg(CSR_REV, 16'd0);
         end else begin
            write_reg(CSR_CPR, pick_edge(16'd2, 16'hFFFF));
            write_reg(CSR_POLES, pick_edge(16'd1, 16'd255));
            write_reg(CSR_OFFSET, pick_edge(16'd0, 16'hFFFF));
            write_reg(CSR_REV, 16'($urandom_range(1)));
            // a change of scale alone, leaving the previous count stale
            if ($urandom_range(3) == 0) write_reg(CSR_CPR, pick_edge(16'd2, 16'hFFFF));
            write_reg(CSR_THRESH, pick_edge(16'd1, 16'd6));
         end
         gaps_on = !(phase == 4);
         // mostly a start followed by updates, some noise
         c.typed = 1'b0;
         c.status = ST_OK;
         if ($urandom_range(5) != 0) begin
            c.func = FN_START;
            c.raw = 12'($urandom_range(4095));
            c.ok = $urandom_range(9) != 0;
            c.us = 20'($urandom_range(20'hFFFFF));
            send_cmd(c);
            n++;
         end
         walk = 12'($urandom_range(4095));
         repeat ($urandom_range(70, 30)) begin
            c.func = FN_UPDATE;
            if ($urandom_range(1)) walk = walk + 12'($urandom_range(80)) - 12'd40;
            else walk = 12'($urandom_range(4095));
            c.raw = walk;
            c.ok = $urandom_range(7) != 0;
            c.us = pick_us();
            case ($urandom_range(29))
               0: c.func = FN_STOP;
               1: c.func = FN_ZERO;
               2: c.func = FN_START;
               default: ;
            endcase
            send_cmd(c);
            n++;
         end
         wait_idle();
         phase++;
      end

      // final drain with a bound
      req_chan.valid <= 1'b0;
      guard = 0;
      while (expected_results.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (200) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         mismatches++;
      end
      $display("covered %0d accepted updates, %0d read failures, %0d register writes",
               updates_done, failures_seen, configs_done);
      $display("across %0d register settings with random stalls on both channels", phase);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
